// ===== rtl/htbd_pkg.sv =====
package htbd_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int IDX_W       = 9;
  localparam int SYM_W       = 8;
  localparam int COUNT_W     = 31;
  localparam int BIT_CNT_W   = 4;
  // wide enough to compare any slot number against the largest table
  localparam int IDX_WIDE_W  = 13;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [IDX_W-1:0]   node_index;
    logic               node_is_leaf;
    logic               has_left;
    logic               has_right;
    logic [IDX_W-1:0]   left_child;
    logic [IDX_W-1:0]   right_child;
    logic [SYM_W-1:0]   node_symbol;
    logic [COUNT_W-1:0] symbol_count;
    logic [BYTE_BITS-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             done_res;
    logic             error;
  } result_t;

  typedef struct packed {
    logic             leaf;
    logic             has_left;
    logic             has_right;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
  } node_t;

endpackage

// ===== rtl/huffman_tree_bit_decoder.sv =====
// Huffman decoder that walks a code tree held in an on-chip node table
// (slot 0 is the root). Load words write one node, a start word returns the
// walk to the root, clears the error flag and sets the symbol count, and a
// data word is decoded MSB first, one tree step per bit. A data word first
// fetches the current node, then steps through its eight bits, emits the
// symbol of each fetched child that is a leaf, closes the walk and hands off
// the last symbol. A word that runs the symbol count out drops its remaining
// bits and finishes sooner. The node table has a single read port, one read
// per tree step; results stalled at the output hold the walk. The node table
// has no clearing pass and its contents are undefined until loaded.
module huffman_tree_bit_decoder #(
  parameter int TREE_NODES  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  htbd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output htbd_pkg::result_t result
);
  import htbd_pkg::*;

  localparam int NODE_AW = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
  localparam logic [IDX_WIDE_W-1:0] TREE_LIMIT = IDX_WIDE_W'(TREE_NODES);
  localparam logic [SYM_W-1:0] SYM_MASK =
    (SYMBOL_BITS >= SYM_W) ? {SYM_W{1'b1}} : SYM_W'((1 << SYMBOL_BITS) - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  node_t mem [TREE_NODES];
  node_t rdata;
  node_t root;

  state_t                state, state_next;
  logic [BYTE_BITS-1:0]  shreg, shreg_next;
  logic [BIT_CNT_W-1:0]  bits_left, bits_left_next;
  logic [NODE_AW-1:0]    current_node, current_node_next;
  logic [COUNT_W-1:0]    symbols_left, symbols_left_next;
  logic                  walk_error, walk_error_next;
  logic                  cur_is_root, cur_is_root_next;
  logic                  child_pend, child_pend_next;
  logic                  pend_valid, pend_valid_next;
  logic [SYM_W-1:0]      pend_sym, pend_sym_next;
  logic                  pend_done, pend_done_next;
  logic                  pend_err, pend_err_next;

  logic                  accept;
  logic                  out_free;
  logic                  emit, emit_ok;
  logic [SYM_W-1:0]      emit_sym;
  logic                  push, push_last;
  logic                  mem_we;
  logic [NODE_AW-1:0]    mem_waddr;
  node_t                 mem_wdata;
  logic                  rd_en;
  logic [NODE_AW-1:0]    rd_addr;
  node_t                 cur;
  logic                  bit_val;
  logic                  child_ok;
  logic [IDX_WIDE_W-1:0] child_wide;
  logic [IDX_WIDE_W-1:0] load_idx_wide;
  logic                  child_bad;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign emit_ok    = !pend_valid || out_free;

  assign cur        = cur_is_root ? root : rdata;
  assign bit_val    = shreg[BYTE_BITS-1];
  assign child_ok   = bit_val ? cur.has_right : cur.has_left;
  assign child_wide = IDX_WIDE_W'(bit_val ? cur.right : cur.left);
  assign child_bad  = !child_ok || (child_wide >= TREE_LIMIT);

  assign load_idx_wide = IDX_WIDE_W'(item.node_index);
  assign mem_waddr     = load_idx_wide[NODE_AW-1:0];
  assign mem_wdata     = '{leaf:      item.node_is_leaf,
                           has_left:  item.has_left,
                           has_right: item.has_right,
                           left:      item.left_child,
                           right:     item.right_child,
                           sym:       item.node_symbol & SYM_MASK};

  always_comb begin
    state_next        = state;
    shreg_next        = shreg;
    bits_left_next    = bits_left;
    current_node_next = current_node;
    symbols_left_next = symbols_left;
    walk_error_next   = walk_error;
    cur_is_root_next  = cur_is_root;
    child_pend_next   = child_pend;
    pend_valid_next   = pend_valid;
    pend_sym_next     = pend_sym;
    pend_done_next    = pend_done;
    pend_err_next     = pend_err;
    emit              = 1'b0;
    emit_sym          = cur.sym;
    push              = 1'b0;
    push_last         = 1'b0;
    mem_we            = 1'b0;
    rd_en             = 1'b0;
    rd_addr           = current_node;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.command)
            CMD_LOAD: begin
              mem_we = (load_idx_wide < TREE_LIMIT);
            end
            CMD_START: begin
              current_node_next = '0;
              symbols_left_next = item.symbol_count;
              walk_error_next   = 1'b0;
            end
            CMD_DATA: begin
              // fetch the node the walk stands on
              shreg_next       = item.data_byte;
              bits_left_next   = BIT_CNT_W'(BYTE_BITS);
              rd_en            = 1'b1;
              cur_is_root_next = 1'b0;
              child_pend_next  = 1'b0;
              state_next       = S_WALK;
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        if (child_pend && rdata.leaf) begin
          // the child fetched by the last tree step is a leaf: emit it, back to root
          emit     = 1'b1;
          emit_sym = rdata.sym;
          if (emit_ok) begin
            child_pend_next   = 1'b0;
            current_node_next = '0;
            cur_is_root_next  = 1'b1;
          end
        end else if (bits_left == '0) begin
          child_pend_next = 1'b0;
          state_next      = S_FLUSH;
        end else if (symbols_left == '0) begin
          // drop the rest of the word
          bits_left_next  = '0;
          child_pend_next = 1'b0;
          state_next      = S_FLUSH;
        end else if (cur.leaf) begin
          emit     = 1'b1;
          emit_sym = cur.sym;
          if (emit_ok) begin
            shreg_next        = shreg << 1;
            bits_left_next    = bits_left - BIT_CNT_W'(1);
            child_pend_next   = 1'b0;
            current_node_next = '0;
            cur_is_root_next  = 1'b1;
          end
        end else begin
          shreg_next      = shreg << 1;
          bits_left_next  = bits_left - BIT_CNT_W'(1);
          child_pend_next = 1'b0;
          if (child_bad) begin
            walk_error_next   = 1'b1;
            current_node_next = '0;
            cur_is_root_next  = 1'b1;
          end else begin
            rd_en             = 1'b1;
            rd_addr           = child_wide[NODE_AW-1:0];
            current_node_next = child_wide[NODE_AW-1:0];
            cur_is_root_next  = 1'b0;
            child_pend_next   = 1'b1;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          push            = 1'b1;
          push_last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // hold each symbol until the next one shows whether it ends the word
    if (emit && emit_ok) begin
      push              = pend_valid;
      push_last         = 1'b0;
      pend_valid_next   = 1'b1;
      pend_sym_next     = emit_sym;
      pend_done_next    = (symbols_left == COUNT_W'(1));
      pend_err_next     = walk_error;
      symbols_left_next = symbols_left - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (mem_we && (mem_waddr == '0)) begin
      root <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bits_left    <= '0;
      current_node <= '0;
      symbols_left <= '0;
      walk_error   <= 1'b0;
      cur_is_root  <= 1'b1;
      child_pend   <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      bits_left    <= bits_left_next;
      current_node <= current_node_next;
      symbols_left <= symbols_left_next;
      walk_error   <= walk_error_next;
      cur_is_root  <= cur_is_root_next;
      child_pend   <= child_pend_next;
      pend_valid   <= pend_valid_next;
      if (push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    shreg     <= shreg_next;
    pend_sym  <= pend_sym_next;
    pend_done <= pend_done_next;
    pend_err  <= pend_err_next;
    if (push) begin
      result <= '{symbol:   pend_sym,
                  last:     push_last,
                  done_res: pend_done,
                  error:    pend_err};
    end
  end

endmodule

// ===== verif/huffman_tree_bit_decoder_test.sv =====
module huffman_tree_bit_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import htbd_pkg::*;

  localparam int SLOTS = 1 << IDX_W;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_MAX = 10;
  // no operation is assigned to this code; the block must ignore it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // stimulus side
  item_t pending_items[$];
  int    items_queued = 0;
  bit    slot_loaded[SLOTS];
  int    loaded_slots[$];
  int    send_idle_pct = 0;
  int    stall_pct = 0;
  int    hold_left = 0;
  int    hold_req = 0;
  int    hold_seen = 0;
  logic  item_taken = 1'b0;

  // decoder state as predicted
  node_t          tree_mem[SLOTS];
  logic [IDX_W-1:0]   walk_node = '0;
  logic [COUNT_W-1:0] left_count = '0;
  logic           walk_err = 1'b0;
  result_t        expected_symbols[$];

  int words_accepted = 0;
  int symbols_checked = 0;
  int files_finished = 0;
  int error_symbols = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  huffman_tree_bit_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void decode_word(input item_t it);
    result_t burst[BYTE_BITS];
    node_t   cur;
    logic [IDX_W-1:0] child;
    logic    bitv;
    logic    present;
    logic    emit;
    logic [SYM_W-1:0] sym;
    int      n;
    int      b;
    n = 0;
    case (it.command)
      CMD_LOAD: begin
        tree_mem[it.node_index] = '{leaf: it.node_is_leaf, has_left: it.has_left,
                                    has_right: it.has_right, left: it.left_child,
                                    right: it.right_child, sym: it.node_symbol};
      end
      CMD_START: begin
        walk_node = '0;
        left_count = it.symbol_count;
        walk_err = 1'b0;
      end
      CMD_DATA: begin
        for (b = BYTE_BITS - 1; b >= 0; b--) begin
          // drop the rest of the byte once the file is complete
          if (left_count == 0) break;
          cur = tree_mem[walk_node];
          bitv = it.data_byte[b];
          emit = 1'b0;
          sym = '0;
          if (cur.leaf) begin
            // one-symbol tree: each bit yields the root symbol
            emit = 1'b1;
            sym = cur.sym;
            walk_node = '0;
          end else begin
            child = bitv ? cur.right : cur.left;
            present = bitv ? cur.has_right : cur.has_left;
            if (!present) begin
              walk_err = 1'b1;
              walk_node = '0;
            end else if (tree_mem[child].leaf) begin
              emit = 1'b1;
              sym = tree_mem[child].sym;
              walk_node = '0;
            end else begin
              walk_node = child;
            end
          end
          if (emit) begin
            left_count = left_count - 1'b1;
            burst[n].symbol = sym;
            burst[n].last = 1'b0;
            burst[n].done_res = (left_count == 0);
            burst[n].error = walk_err;
            n++;
          end
        end
        for (b = 0; b < n; b++) begin
          if (b == n - 1) burst[b].last = 1'b1;
          expected_symbols.push_back(burst[b]);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic item_t rand_item(input logic [1:0] cmd);
    item_t it;
    logic [31:0] rnd;
    rnd = $urandom();
    it.command = cmd;
    it.node_index = IDX_W'($urandom_range(SLOTS - 1));
    it.node_is_leaf = 1'($urandom_range(1));
    it.has_left = 1'($urandom_range(1));
    it.has_right = 1'($urandom_range(1));
    it.left_child = IDX_W'($urandom_range(SLOTS - 1));
    it.right_child = IDX_W'($urandom_range(SLOTS - 1));
    it.node_symbol = SYM_W'($urandom_range(255));
    it.symbol_count = rnd[COUNT_W-1:0];
    it.data_byte = BYTE_BITS'($urandom_range(255));
    return it;
  endfunction

  task automatic queue_item(input item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic mark_loaded(input int slot);
    if (!slot_loaded[slot]) begin
      slot_loaded[slot] = 1'b1;
      loaded_slots.push_back(slot);
    end
  endtask

  // pointers only ever name loaded slots, so no walk can touch an unwritten one
  function automatic int pick_loaded();
    return loaded_slots[$urandom_range(loaded_slots.size() - 1)];
  endfunction

  task automatic load_node(input int slot, input bit leaf, input bit hl, input bit hr,
                           input int l, input int r, input logic [SYM_W-1:0] sym);
    item_t it;
    it = rand_item(CMD_LOAD);
    it.node_index = IDX_W'(slot);
    it.node_is_leaf = leaf;
    it.has_left = hl;
    it.has_right = hr;
    it.left_child = IDX_W'(l);
    it.right_child = IDX_W'(r);
    it.node_symbol = sym;
    mark_loaded(slot);
    queue_item(it);
  endtask

  task automatic queue_start(input logic [COUNT_W-1:0] count);
    item_t it;
    it = rand_item(CMD_START);
    it.symbol_count = count;
    queue_item(it);
  endtask

  task automatic queue_byte(input logic [7:0] data);
    item_t it;
    it = rand_item(CMD_DATA);
    it.data_byte = data;
    queue_item(it);
  endtask

  // grow a code tree by splitting leaves; pruned trees may have missing children
  task automatic build_tree(input int leaves, input bit prune);
    int slot_of[$];
    bit is_leaf[$];
    int kid[$][2];
    bit in_tree[SLOTS];
    int pick;
    int s;
    int i;
    int j;
    int k;
    bit hl;
    bit hr;
    slot_of.push_back(0);
    is_leaf.push_back(1'b1);
    kid.push_back('{0, 0});
    in_tree[0] = 1'b1;
    for (k = 1; k < leaves; k++) begin
      do pick = $urandom_range(slot_of.size() - 1); while (!is_leaf[pick]);
      is_leaf[pick] = 1'b0;
      for (j = 0; j < 2; j++) begin
        do s = $urandom_range(SLOTS - 1); while (in_tree[s]);
        in_tree[s] = 1'b1;
        kid[pick][j] = slot_of.size();
        slot_of.push_back(s);
        is_leaf.push_back(1'b1);
        kid.push_back('{0, 0});
      end
    end
    for (i = 0; i < slot_of.size(); i++) mark_loaded(slot_of[i]);
    for (i = 0; i < slot_of.size(); i++) begin
      if (is_leaf[i]) begin
        load_node(slot_of[i], 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  pick_loaded(), pick_loaded(), SYM_W'($urandom_range(255)));
      end else begin
        hl = !(prune && $urandom_range(2) == 0);
        hr = !(prune && $urandom_range(2) == 0);
        load_node(slot_of[i], 1'b0, hl, hr,
                  hl ? slot_of[kid[i][0]] : pick_loaded(),
                  hr ? slot_of[kid[i][1]] : pick_loaded(),
                  SYM_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic add_noise();
    int s;
    case ($urandom_range(2))
      0: queue_item(rand_item(CMD_UNUSED));
      1: queue_start(COUNT_W'($urandom_range(12)));
      default: begin
        // overwrite any slot, possibly one on the live tree
        s = $urandom_range(SLOTS - 1);
        mark_loaded(s);
        load_node(s, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), pick_loaded(), pick_loaded(),
                  SYM_W'($urandom_range(255)));
      end
    endcase
  endtask

  task automatic gen_file();
    logic [31:0] rnd;
    int roll;
    int nbytes;
    build_tree(($urandom_range(7) == 0) ? 1 : $urandom_range(2, 8), $urandom_range(3) == 0);
    rnd = $urandom();
    roll = $urandom_range(9);
    if (roll == 0) queue_start('0);
    else if (roll == 1) queue_start({1'b1, rnd[COUNT_W-2:0]});
    else queue_start(COUNT_W'($urandom_range(1, 24)));
    nbytes = $urandom_range(1, 6);
    repeat (nbytes) begin
      if ($urandom_range(7) == 0) add_noise();
      queue_byte(BYTE_BITS'($urandom_range(255)));
    end
  endtask

  task automatic random_phase(input int words);
    int stop_at;
    stop_at = items_queued + words;
    while (items_queued < stop_at) gen_file();
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (words_accepted != items_queued || expected_symbols.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver and receiver, both change at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      result_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted word, check each accepted result
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display({"MISMATCH cycle %0d, %s: expected sym=%02h last=%b done=%b err=%b,",
                " got sym=%02h last=%b done=%b err=%b"},
               cycle_count, what, want.symbol, want.last, want.done_res, want.error,
               got.symbol, got.last, got.done_res, got.error);
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    item_taken <= item_valid && !item_stall && !rst;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        decode_word(item);
        words_accepted++;
      end
      if (result_valid && !result_stall) begin
        if (expected_symbols.size() == 0) begin
          report_mismatch("no symbol pending", '0, result);
        end else begin
          want = expected_symbols.pop_front();
          symbols_checked++;
          if (want.done_res) files_finished++;
          if (want.error) error_symbols++;
          if (result.symbol !== want.symbol || result.last !== want.last ||
              result.done_res !== want.done_res || result.error !== want.error)
            report_mismatch("field differs", want, result);
        end
      end
    end
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d symbols still pending",
               cycle_count, expected_symbols.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // bytes before any start find a zero count and are dropped
    queue_byte(8'hFF);
    queue_item(rand_item(CMD_UNUSED));
    // one-symbol tree
    load_node(0, 1'b1, 1'b1, 1'b1, 0, 0, 8'hFF);
    queue_start(COUNT_W'(10));
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'hA5);
    // small tree with one missing child under slot 256
    load_node(511, 1'b1, 1'b1, 1'b1, 511, 511, 8'h00);
    load_node(1, 1'b1, 1'b0, 1'b0, 0, 0, 8'h7F);
    load_node(256, 1'b0, 1'b1, 1'b0, 1, 0, 8'h5C);
    load_node(0, 1'b0, 1'b1, 1'b1, 511, 256, 8'h00);
    queue_start({COUNT_W{1'b1}});
    queue_byte(8'h5A);
    queue_byte(8'hC3);
    queue_start(COUNT_W'(3));
    queue_byte(8'h80);
    queue_start('0);
    queue_byte(8'h3C);
    queue_start(COUNT_W'(5));
    queue_byte(8'h00);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_drained();

    // no idling, with one long output hold-off to back up the input
    @(posedge clk);
    hold_req++;
    random_phase(42);
    wait_drained();

    send_idle_pct = 67;
    stall_pct = 0;
    random_phase(42);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 67;
    random_phase(42);
    wait_drained();

    send_idle_pct = 23;
    stall_pct = 23;
    random_phase(42);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    mismatch_count += expected_symbols.size();
    $display("Run covered %0d input words over four idle/stall mixes: %0d symbols checked,",
             words_accepted, symbols_checked);
    $display("%0d files decoded to completion, %0d symbols carrying the walk error flag.",
             files_finished, error_symbols);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
